// File: design/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_pkg
// Shared types and constants for the three-stack core.
// ----------------------------------------------------------------------------
package tss_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int WORD_WIDTH    = 32;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_BADID = 2'd3
   } status_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STACK_LOW  = 2'd0,
      STACK_DOWN = 2'd1,
      STACK_MID  = 2'd2,
      STACK_BAD  = 2'd3
   } stack_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EVAL = 2'd1,
      S_READ = 2'd2
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic eval_done;
      logic read;
      logic read_done;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic pop_hit;
   } stat_type;

endpackage

// File: design/tss_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/tss_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_datapath
// Request latch, stack pointers, status decision, storage and result register.
// ----------------------------------------------------------------------------
module tss_datapath #(
   parameter int DEPTH = tss_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tss_pkg::ctl_type                  ctl,
   output tss_pkg::stat_type                 stat,
   input  logic                              req_operation,
   input  logic [1:0]                        req_stack_id,
   input  logic signed [tss_pkg::WORD_WIDTH-1:0] req_value,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [tss_pkg::WORD_WIDTH-1:0] rsp_popped
);

   localparam int PW = $clog2(DEPTH);
   localparam logic [PW-1:0] HALF = PW'(DEPTH / 2);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [PW-1:0] ONE  = PW'(1);

   logic                              op_ff;
   logic [1:0]                        id_ff;
   logic [tss_pkg::WORD_WIDTH-1:0]    value_ff;

   logic [PW-1:0] low_ff, low_in;
   logic [PW-1:0] down_ff, down_in;
   logic [PW-1:0] mid_ff, mid_in;

   logic                              rsp_valid_ff;
   logic [1:0]                        rsp_status_ff;
   logic [tss_pkg::WORD_WIDTH-1:0]    rsp_popped_ff;

   tss_pkg::status_type            status;
   logic                           gap_open;
   logic [PW-1:0]                  addr;
   logic                           wr_en;
   logic [tss_pkg::WORD_WIDTH-1:0] rd_data;

   assign gap_open = {1'b0, down_ff} > ({1'b0, mid_ff} + (PW + 1)'(1));

   always_comb begin
      status = tss_pkg::ST_OK;
      addr   = low_ff;
      unique case (tss_pkg::stack_type'(id_ff))
         tss_pkg::STACK_LOW: begin
            if (op_ff == tss_pkg::OP_PUSH) begin
               addr = low_ff + ONE;
               if (low_ff == HALF) status = tss_pkg::ST_FULL;
            end else begin
               addr = low_ff;
               if (low_ff == '0) status = tss_pkg::ST_EMPTY;
            end
         end
         tss_pkg::STACK_DOWN: begin
            if (op_ff == tss_pkg::OP_PUSH) begin
               addr = down_ff - ONE;
               if (!gap_open) status = tss_pkg::ST_FULL;
            end else begin
               addr = down_ff;
               if (down_ff == LAST) status = tss_pkg::ST_EMPTY;
            end
         end
         tss_pkg::STACK_MID: begin
            if (op_ff == tss_pkg::OP_PUSH) begin
               addr = mid_ff + ONE;
               if (!gap_open) status = tss_pkg::ST_FULL;
            end else begin
               addr = mid_ff;
               if (mid_ff == HALF) status = tss_pkg::ST_EMPTY;
            end
         end
         default: begin
            status = tss_pkg::ST_BADID;
         end
      endcase
   end

   assign stat.pop_hit = (op_ff == tss_pkg::OP_POP) && (status == tss_pkg::ST_OK);
   assign wr_en = ctl.eval_done && (op_ff == tss_pkg::OP_PUSH) && (status == tss_pkg::ST_OK);

   always_comb begin
      low_in  = low_ff;
      down_in = down_ff;
      mid_in  = mid_ff;
      if (wr_en || ctl.read_done) begin
         unique case (tss_pkg::stack_type'(id_ff))
            tss_pkg::STACK_LOW:  low_in  = wr_en ? low_ff + ONE : low_ff - ONE;
            tss_pkg::STACK_DOWN: down_in = wr_en ? down_ff - ONE : down_ff + ONE;
            tss_pkg::STACK_MID:  mid_in  = wr_en ? mid_ff + ONE : mid_ff - ONE;
            default: ;
         endcase
      end
   end

   tss_ram #(
      .WIDTH (tss_pkg::WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data (value_ff),
      .rd_en   (ctl.read),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         op_ff    <= req_operation;
         id_ff    <= req_stack_id;
         value_ff <= req_value;
      end
      if (ctl.eval_done) begin
         rsp_status_ff <= status;
         rsp_popped_ff <= '1;
      end else if (ctl.read_done) begin
         rsp_status_ff <= tss_pkg::ST_OK;
         rsp_popped_ff <= rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         down_ff      <= LAST;
         mid_ff       <= HALF;
         rsp_valid_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         down_ff      <= down_in;
         mid_ff       <= mid_in;
         rsp_valid_ff <= ctl.eval_done || ctl.read_done;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_popped = rsp_popped_ff;

endmodule

// File: design/tss_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tss_controller
// Sequencer: accept, evaluate, optional storage read, finish.
// ----------------------------------------------------------------------------
module tss_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tss_pkg::stat_type stat,
   output tss_pkg::ctl_type  ctl
);

   tss_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tss_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         tss_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.load = 1'b1;
               state_in = tss_pkg::S_EVAL;
            end
         end
         tss_pkg::S_EVAL: begin
            if (stat.pop_hit) begin
               ctl.read = 1'b1;
               state_in = tss_pkg::S_READ;
            end else begin
               ctl.eval_done = 1'b1;
               state_in      = tss_pkg::S_IDLE;
            end
         end
         tss_pkg::S_READ: begin
            ctl.read_done = 1'b1;
            state_in      = tss_pkg::S_IDLE;
         end
         default: begin
            state_in = tss_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// File: design/three_stacks_shared_memory_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_stacks_shared_memory_core
// Three LIFO stacks in one shared memory of DEPTH words.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Its result appears on
// rsp_status and rsp_popped for one cycle with rsp_valid high and must be
// taken then: there is no way to hold it off. A push, a refused push, a pop
// of an empty stack or a bad stack id takes its result from the evaluate
// state into the result register; a successful pop adds a read state for the
// registered read port of the storage RAM. The next item can be accepted in
// the cycle the result is shown, and not before the last one is through.
// ----------------------------------------------------------------------------
module three_stacks_shared_memory_core #(
   parameter int DEPTH = tss_pkg::DEPTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_operation,
   input  logic [1:0]                            req_stack_id,
   input  logic signed [tss_pkg::WORD_WIDTH-1:0] req_value,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic signed [tss_pkg::WORD_WIDTH-1:0] rsp_popped
);

   tss_pkg::ctl_type  ctl;
   tss_pkg::stat_type stat;

   tss_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .ctl   (ctl)
   );

   tss_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .stat          (stat),
      .req_operation (req_operation),
      .req_stack_id  (req_stack_id),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_popped    (rsp_popped)
   );

endmodule
